>>> sv/pt100_pkg.sv
// ----------------------------------------------------------------------------
// Pt100 linearizer package
// Shared widths, knot tables, segment gradients and the stage payload type
// for the Pt100 resistance-to-temperature pipeline.
// ----------------------------------------------------------------------------
package pt100_pkg;

   // Field widths.
   localparam int RES_W  = 16;   // resistance, unsigned Q8.8 ohms
   localparam int TEMP_W = 13;   // temperature, signed 1/16 degC

   // Knot table size and the derived index widths.
   localparam int KNOT_COUNT = 36;
   localparam int SEG_IDX_W  = $clog2(KNOT_COUNT);
   localparam int KNOT_FINE_LAST = 32;   // last knot of the 5-degree grid

   // Datapath widths: the widest segment spans 5120 counts, so the offset
   // fits in 13 bits; the largest gradient is below 2**14.
   localparam int OFFS_W = 13;
   localparam int GRAD_W = 14;
   localparam int PROD_W = OFFS_W + GRAD_W;
   localparam int FRAC_SHIFT = 16;
   localparam int FRAC_W = PROD_W + 1 - FRAC_SHIFT;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(32768);

   // Clamp values in 1/16 degC.
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -13'sd800;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sd4000;

   // Knot resistances in Q8.8 counts.
   localparam logic [RES_W-1:0] KNOT_RES [KNOT_COUNT] = '{
      16'd20559, 16'd21066, 16'd21573, 16'd22080, 16'd22584, 16'd23089,
      16'd23593, 16'd24095, 16'd24599, 16'd25098, 16'd25600, 16'd26099,
      16'd26598, 16'd27098, 16'd27594, 16'd28091, 16'd28588, 16'd29084,
      16'd29578, 16'd30072, 16'd30566, 16'd31058, 16'd31549, 16'd32041,
      16'd32530, 16'd33019, 16'd33508, 16'd33997, 16'd34483, 16'd34970,
      16'd35456, 16'd35940, 16'd36426, 16'd40271, 16'd45015, 16'd50135
   };

   // Q16 reciprocal gradient of the segment that ends at each knot.
   // Entry zero has no segment below it and is never selected.
   localparam logic [GRAD_W-1:0] SEG_GRAD [KNOT_COUNT] = '{
      14'd0,
      14'd10341, 14'd10341, 14'd10341, 14'd10403, 14'd10382, 14'd10403,
      14'd10444, 14'd10403, 14'd10507, 14'd10444, 14'd10507, 14'd10507,
      14'd10486, 14'd10570, 14'd10549, 14'd10549, 14'd10570, 14'd10613,
      14'd10613, 14'd10613, 14'd10656, 14'd10678, 14'd10656, 14'd10722,
      14'd10722, 14'd10722, 14'd10722, 14'd10788, 14'd10766, 14'd10788,
      14'd10832, 14'd10788, 14'd10908, 14'd11052, 14'd10240
   };

   // Located beat handed from the segment search to the interpolator.
   typedef struct packed {
      logic                 below;
      logic                 above;
      logic [SEG_IDX_W-1:0] seg;
      logic [RES_W-1:0]     res;
   } loc_type;

   // Knot temperature in 5-degree steps to 110 degC, then 150, 200, 250 degC.
   function automatic logic signed [TEMP_W-1:0] knot_temp(
      input logic [SEG_IDX_W-1:0] idx
   );
      int t;
      if (int'(idx) <= KNOT_FINE_LAST) begin
         t = -800 + 80 * int'(idx);
      end else begin
         t = 2400 + 800 * (int'(idx) - (KNOT_FINE_LAST + 1));
      end
      return TEMP_W'(t);
   endfunction

endpackage

>>> sv/pt100_skid.sv
// ----------------------------------------------------------------------------
// Pt100 input skid buffer
// Holds one request beat while the pipeline is frozen, so that the request
// stall comes straight from a register.
// ----------------------------------------------------------------------------
module pt100_skid
   import pt100_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [RES_W-1:0] req_resistance,
   output logic             req_stall,
   input  logic             advance,
   output logic             pipe_valid,
   output logic [RES_W-1:0] pipe_res
);

   logic             skid_valid_ff, skid_valid_in;
   logic [RES_W-1:0] skid_res_ff, skid_res_in;
   logic             accept;

   // A beat is taken only while the skid slot is empty.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;

   // The parked beat goes first.
   assign pipe_valid = skid_valid_ff | accept;
   assign pipe_res   = skid_valid_ff ? skid_res_ff : req_resistance;

   // Park a beat that arrives while the pipeline is frozen.
   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (skid_valid_ff) begin
         if (advance) begin
            skid_valid_in = 1'b0;
         end
      end else if (accept && !advance) begin
         skid_valid_in = 1'b1;
         skid_res_in   = req_resistance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      skid_res_ff <= skid_res_in;
   end

endmodule

>>> sv/pt100_locate.sv
// ----------------------------------------------------------------------------
// Pt100 segment search
// Compares the resistance against every knot in parallel, then turns the
// thermometer code into a segment index. Two register stages.
// ----------------------------------------------------------------------------
module pt100_locate
   import pt100_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             pipe_valid,
   input  logic [RES_W-1:0] pipe_res,
   output logic             loc_valid,
   output loc_type          loc
);

   localparam int INNER_N = KNOT_COUNT - 2;

   // Stage one: knot compares.
   logic               s1_valid_ff;
   logic [RES_W-1:0]   s1_res_ff;
   logic               s1_below_ff, s1_above_ff;
   logic [INNER_N-1:0] s1_ge_ff, s1_ge_in;

   // Stage two: segment index.
   logic               s2_valid_ff;
   loc_type            s2_loc_ff, s2_loc_in;

   // One compare per inner knot; bit k-1 says the resistance reached knot k.
   always_comb begin
      for (int k = 1; k <= INNER_N; k++) begin
         s1_ge_in[k-1] = pipe_res >= KNOT_RES[k];
      end
   end

   // The first inner knot not reached closes the segment; else the last one.
   always_comb begin
      s2_loc_in.seg = SEG_IDX_W'(KNOT_COUNT - 1);
      for (int k = INNER_N; k >= 1; k--) begin
         if (!s1_ge_ff[k-1]) begin
            s2_loc_in.seg = SEG_IDX_W'(k);
         end
      end
      s2_loc_in.below = s1_below_ff;
      s2_loc_in.above = s1_above_ff;
      s2_loc_in.res   = s1_res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pipe_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s1_res_ff   <= pipe_res;
         s1_ge_ff    <= s1_ge_in;
         s1_below_ff <= pipe_res <= KNOT_RES[0];
         s1_above_ff <= pipe_res >= KNOT_RES[KNOT_COUNT-1];
         s2_loc_ff   <= s2_loc_in;
      end
   end

   assign loc_valid = s2_valid_ff;
   assign loc       = s2_loc_ff;

   // An inside beat always names a real segment.
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      loc_valid && !loc.below && !loc.above |->
         loc.seg != '0 && int'(loc.seg) <= KNOT_COUNT - 1)
      else $error("segment index out of range");

   // The two range flags never both come up.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      loc_valid |-> !(loc.below && loc.above))
      else $error("below and above range both set");

   // An inside beat lies at or above the lower knot of its segment.
   a_seg_lower: assert property (@(posedge clock) disable iff (reset)
      loc_valid && !loc.below && !loc.above |->
         loc.res >= KNOT_RES[loc.seg - SEG_IDX_W'(1)])
      else $error("resistance below its segment");

endmodule

>>> sv/pt100_interp.sv
// ----------------------------------------------------------------------------
// Pt100 interpolator
// Looks up the segment constants, multiplies the offset by the reciprocal
// gradient, rounds and adds the lower knot temperature. Three register
// stages, the last being the result register.
// ----------------------------------------------------------------------------
module pt100_interp
   import pt100_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     loc_valid,
   input  loc_type                  loc,
   output logic                     rsp_valid,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_below_range,
   output logic                     rsp_above_range
);

   // Stage three: segment constants and offset.
   logic                     s3_valid_ff;
   logic [OFFS_W-1:0]        s3_offs_ff, s3_offs_in;
   logic [GRAD_W-1:0]        s3_grad_ff;
   logic signed [TEMP_W-1:0] s3_tlo_ff;
   logic                     s3_below_ff, s3_above_ff;
   logic [SEG_IDX_W-1:0]     lo_idx;
   logic [RES_W-1:0]         diff;

   // Stage four: product.
   logic                     s4_valid_ff;
   logic [PROD_W-1:0]        s4_prod_ff;
   logic signed [TEMP_W-1:0] s4_tlo_ff;
   logic                     s4_below_ff, s4_above_ff;

   // Stage five: result register.
   logic                     s5_valid_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff, s5_temp_in;
   logic                     s5_below_ff, s5_above_ff;
   logic [PROD_W:0]          rounded;
   logic [FRAC_W-1:0]        frac;
   logic signed [TEMP_W:0]   tsum;

   // Offset into the segment; inside the table it is below the segment span.
   assign lo_idx     = loc.seg - SEG_IDX_W'(1);
   assign diff       = loc.res - KNOT_RES[lo_idx];
   assign s3_offs_in = diff[OFFS_W-1:0];

   // Round half up, add the lower knot, or clamp at the table ends.
   assign rounded = {1'b0, s4_prod_ff} + ROUND_HALF;
   assign frac    = rounded[PROD_W:FRAC_SHIFT];
   assign tsum    = {s4_tlo_ff[TEMP_W-1], s4_tlo_ff}
                    + $signed({1'b0, (TEMP_W - FRAC_W)'(0), frac});

   always_comb begin
      priority if (s4_below_ff) begin
         s5_temp_in = TEMP_MIN;
      end else if (s4_above_ff) begin
         s5_temp_in = TEMP_MAX;
      end else begin
         s5_temp_in = tsum[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= loc_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s3_offs_ff  <= s3_offs_in;
         s3_grad_ff  <= SEG_GRAD[loc.seg];
         s3_tlo_ff   <= knot_temp(lo_idx);
         s3_below_ff <= loc.below;
         s3_above_ff <= loc.above;
         s4_prod_ff  <= PROD_W'(s3_offs_ff) * PROD_W'(s3_grad_ff);
         s4_tlo_ff   <= s3_tlo_ff;
         s4_below_ff <= s3_below_ff;
         s4_above_ff <= s3_above_ff;
         s5_temp_ff  <= s5_temp_in;
         s5_below_ff <= s4_below_ff;
         s5_above_ff <= s4_above_ff;
      end
   end

   assign rsp_valid       = s5_valid_ff;
   assign rsp_temperature = s5_temp_ff;
   assign rsp_below_range = s5_below_ff;
   assign rsp_above_range = s5_above_ff;

   // A clamped low beat carries the lowest knot temperature.
   a_below_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_below_range |-> rsp_temperature == TEMP_MIN)
      else $error("below-range beat not clamped");

   // A clamped high beat carries the highest knot temperature.
   a_above_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_above_range |-> rsp_temperature == TEMP_MAX)
      else $error("above-range beat not clamped");

   // Interpolation never leaves the table's temperature span.
   a_temp_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature >= TEMP_MIN && rsp_temperature <= TEMP_MAX)
      else $error("temperature outside table span");

endmodule

>>> sv/pt100_resistance_to_temperature.sv
// Path: an accepted beat passes the search registers s1 and s2, then the
//    interpolator registers s3 to s5, and waits in s5 while rsp_stall holds it.
// Throughput: one beat per cycle unless rsp_stall holds it; five-stage
//    pipeline with a single multiplier stage; all knots compare in parallel.
// Reset (synchronous, active high) clears all valid bits and the input skid.
// ----------------------------------------------------------------------------
// Pt100 resistance-to-temperature converter
// Piecewise-linear Pt100 linearization over a fixed 36-knot table with one
// constant reciprocal gradient per segment; out-of-table readings clamp.
// ----------------------------------------------------------------------------
module pt100_resistance_to_temperature
   import pt100_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [RES_W-1:0]         req_resistance,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_below_range,
   output logic                     rsp_above_range,
   input  logic                     rsp_stall
);

   logic             advance;
   logic             pipe_valid;
   logic [RES_W-1:0] pipe_res;
   logic             loc_valid;
   loc_type          loc;

   // The whole pipeline moves unless the result register is held.
   assign advance = ~(rsp_valid & rsp_stall);

   pt100_skid u_skid (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_resistance (req_resistance),
      .req_stall      (req_stall),
      .advance        (advance),
      .pipe_valid     (pipe_valid),
      .pipe_res       (pipe_res)
   );

   pt100_locate u_locate (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pipe_valid (pipe_valid),
      .pipe_res   (pipe_res),
      .loc_valid  (loc_valid),
      .loc        (loc)
   );

   pt100_interp u_interp (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .loc_valid       (loc_valid),
      .loc             (loc),
      .rsp_valid       (rsp_valid),
      .rsp_temperature (rsp_temperature),
      .rsp_below_range (rsp_below_range),
      .rsp_above_range (rsp_above_range)
   );

endmodule
